@@ hdl/assert_macros.svh @@
// Assertion macros used by the checker file.
// Depends on nothing; every macro samples on the rising clock edge and is off during reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hdl/lgf_pkg.sv @@
// Shared types, codes and payoff helpers of the lattice game update core.
// Depends on nothing; used by the Fermi unit and the top level.
package lgf_pkg;

    localparam int DIFF_W    = 15;
    localparam int PAY_W     = 12;
    localparam int ACC_W     = 14;
    localparam int PROB_W    = 17;
    localparam int CNT_W     = 4;
    localparam logic [CNT_W-1:0] LAST_READ = 4'd9;

    typedef enum logic [1:0] {
        KIND_LOAD   = 2'd0,
        KIND_UPDATE = 2'd1,
        KIND_READ   = 2'd2,
        KIND_SPARE  = 2'd3
    } kind_t;

    typedef enum logic [2:0] {
        CFG_TEMPTATION = 3'd0,
        CFG_COST       = 3'd1,
        CFG_INV_NOISE  = 3'd2,
        CFG_LONG_RANGE = 3'd3,
        CFG_MUTATION   = 3'd4
    } cfg_index_t;

    typedef struct packed {
        logic                     valid;
        logic signed [DIFF_W-1:0] diff;
    } fermi_req_t;

    typedef struct packed {
        logic              valid;
        logic [PROB_W-1:0] prob;
    } fermi_rsp_t;

    // A strategy code of three folds back to zero.
    function automatic logic [1:0] fold3(input logic [1:0] v);
        return (v == 2'd3) ? 2'd0 : v;
    endfunction

    // Q4.8 payoff of strategy a played against strategy b.
    function automatic logic signed [PAY_W-1:0] pay(input logic [1:0] a, input logic [1:0] b,
                                                     input logic [9:0] tempt,
                                                     input logic [8:0] cost);
        logic signed [PAY_W-1:0] c;
        logic signed [PAY_W-1:0] r;
        c = cost[8] ? PAY_W'(256) : PAY_W'({1'b0, cost[7:0]});
        if (a == 2'd0)
        begin
            r = (b == 2'd1) ? PAY_W'({1'b0, tempt}) : '0;
        end
        else if (a == 2'd1)
        begin
            r = (b == 2'd0) ? '0 : PAY_W'(256);
        end
        else
        begin
            r = (b == 2'd0) ? -c : PAY_W'(256) - c;
        end
        return r;
    endfunction

endpackage

@@ hdl/lattice_game_fermi_update_core.sv @@
// Top level of the lattice game update core: sequencer, grid memory, configuration.
// Depends on lgf_pkg, lgf_ram and lgf_fermi.
//
// One item is worked on at a time, and the grid lives in a single-port memory, so
// the time per item is set by that memory port: a load writes one cell, a read reads
// one, and an update attempt makes ten reads of focal, partner and their eight
// neighbors, passes through the Fermi unit and ends with a write-back, or skips the
// Fermi step and write-back when the two strategies match. A finished result waits
// in an output register while the next item is taken in. Grid cells hold no defined
// value until loaded; configuration is written through the cfg channel, which is
// always ready.
module lattice_game_fermi_update_core import lgf_pkg::*; #(
    parameter int GRID_SIDE       = 128,
    parameter int SIGMOID_ENTRIES = 256
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // row, col, load_value, direction, long_range_draw, far_row, far_col,
    // accept_draw, mutation_draw, mutation_value, zero fill
    input  logic [87:0] s_tdata,
    // kind
    input  logic [1:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // cell_value, imitated, mutated, zero fill
    output logic [7:0]  m_tdata,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    localparam int CW = $clog2(GRID_SIDE);
    localparam int RW = CW + 1;
    localparam int AW = $clog2(GRID_SIDE * GRID_SIDE);
    localparam logic [RW-1:0] SIDE_R = RW'(GRID_SIDE);
    localparam logic [CW-1:0] SIDE_M1 = CW'(GRID_SIDE - 1);
    localparam logic [AW-1:0] SIDE_A = AW'(GRID_SIDE);

    typedef enum logic [2:0] {
        ST_IDLE, ST_PREP, ST_READ, ST_DRAIN, ST_EVAL, ST_FERMI, ST_WRITE, ST_FINISH
    } state_t;

    // Remainder by the grid side, one restoring step per input bit.
    function automatic logic [CW-1:0] reduce(input logic [6:0] v);
        logic [RW-1:0] rem;
        int i;
        rem = '0;
        for (i = 6; i >= 0; i--)
        begin
            rem = {rem[RW-2:0], v[i]};
            if (rem >= SIDE_R)
            begin
                rem = rem - SIDE_R;
            end
        end
        return rem[CW-1:0];
    endfunction

    function automatic logic [CW-1:0] inc_w(input logic [CW-1:0] v);
        return (v == SIDE_M1) ? '0 : v + 1'b1;
    endfunction

    function automatic logic [CW-1:0] dec_w(input logic [CW-1:0] v);
        return (v == '0) ? SIDE_M1 : v - 1'b1;
    endfunction

    function automatic logic [AW-1:0] addr_of(input logic [CW-1:0] r, input logic [CW-1:0] c);
        return AW'(r) * SIDE_A + AW'(c);
    endfunction

    state_t state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic rd_vld_reg;
    logic [CNT_W-1:0] rd_idx_reg;
    logic m_tvalid_reg, m_tvalid_next;
    logic [3:0] m_tdata_reg, m_tdata_next;
    logic [9:0] temptation_reg;
    logic [8:0] cost_reg;
    logic [15:0] inv_noise_reg;
    logic [15:0] long_range_reg;
    logic [15:0] mutation_reg;

    kind_t kind_reg;
    logic [CW-1:0] row_reg, col_reg, far_row_reg, far_col_reg, prow_reg, pcol_reg;
    logic [1:0] lv_reg, dir_reg, mutv_reg, sx_reg, sy_reg, res_reg;
    logic lr_hit_reg, mut_hit_reg, imit_reg, mut_reg;
    logic [15:0] acc_draw_reg;
    logic signed [ACC_W-1:0] accp_reg, accf_reg;

    logic mem_we;
    logic [AW-1:0] mem_addr;
    logic [1:0] mem_wdata, mem_rdata;
    logic [CW-1:0] br, bc, nr, nc, prow_next, pcol_next;
    logic [1:0] new_val;
    logic imit_next, mut_next;
    fermi_req_t freq;
    fermi_rsp_t frsp;
    logic accept_in;

    assign s_tready  = (state_reg == ST_IDLE);
    assign accept_in = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = {4'b0, m_tdata_reg};

    lgf_ram #(.WIDTH(2), .DEPTH(GRID_SIDE * GRID_SIDE)) u_grid (
        .clk   (clk),
        .we    (mem_we),
        .addr  (mem_addr),
        .wdata (mem_wdata),
        .rdata (mem_rdata)
    );

    lgf_fermi #(.SIGMOID_ENTRIES(SIGMOID_ENTRIES)) u_fermi (
        .clk           (clk),
        .rst_n         (rst_n),
        .inverse_noise (inv_noise_reg),
        .req           (freq),
        .rsp           (frsp)
    );

    always_comb
    begin
        case (dir_reg)
            2'd0:    begin prow_next = inc_w(row_reg); pcol_next = col_reg; end
            2'd1:    begin prow_next = row_reg; pcol_next = inc_w(col_reg); end
            2'd2:    begin prow_next = dec_w(row_reg); pcol_next = col_reg; end
            default: begin prow_next = row_reg; pcol_next = dec_w(col_reg); end
        endcase
        if (lr_hit_reg)
        begin
            prow_next = far_row_reg;
            pcol_next = far_col_reg;
        end
    end

    // Read order: focal, partner, the partner's four neighbors, the focal's four.
    always_comb
    begin
        br = (cnt_reg <= 4'd5) ? prow_reg : row_reg;
        bc = (cnt_reg <= 4'd5) ? pcol_reg : col_reg;
        case (cnt_reg[1:0])
            2'd2:    begin nr = inc_w(br); nc = bc; end
            2'd3:    begin nr = br; nc = inc_w(bc); end
            2'd0:    begin nr = dec_w(br); nc = bc; end
            default: begin nr = br; nc = dec_w(bc); end
        endcase
        if (cnt_reg == 4'd0)
        begin
            nr = row_reg;
            nc = col_reg;
        end
        else if (cnt_reg == 4'd1)
        begin
            nr = prow_reg;
            nc = pcol_reg;
        end
    end

    always_comb
    begin
        imit_next = acc_draw_reg < frsp.prob[15:0] || frsp.prob[16];
        mut_next  = mut_hit_reg;
        new_val   = mut_next ? mutv_reg : (imit_next ? sy_reg : sx_reg);
    end

    always_comb
    begin
        mem_we    = 1'b0;
        mem_addr  = addr_of(row_reg, col_reg);
        mem_wdata = lv_reg;
        case (state_reg)
            ST_PREP:
            begin
                mem_we = (kind_reg == KIND_LOAD);
            end
            ST_READ:
            begin
                mem_addr = addr_of(nr, nc);
            end
            ST_WRITE:
            begin
                mem_we    = imit_reg || mut_reg;
                mem_wdata = res_reg;
            end
            default:
            begin
                mem_we = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;
        freq.valid    = 1'b0;
        freq.diff     = DIFF_W'(accp_reg) - DIFF_W'(accf_reg);
        case (state_reg)
            ST_IDLE:
            begin
                if (accept_in)
                begin
                    state_next = ST_PREP;
                end
            end
            ST_PREP:
            begin
                cnt_next   = '0;
                state_next = (kind_reg == KIND_LOAD) ? ST_FINISH : ST_READ;
            end
            ST_READ:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == LAST_READ || (kind_reg != KIND_UPDATE && cnt_reg == '0))
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_EVAL;
            end
            ST_EVAL:
            begin
                if (kind_reg == KIND_UPDATE && sx_reg != sy_reg)
                begin
                    freq.valid = 1'b1;
                    state_next = ST_FERMI;
                end
                else
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FERMI:
            begin
                if (frsp.valid)
                begin
                    state_next = ST_WRITE;
                end
            end
            ST_WRITE:
            begin
                state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {mut_reg, imit_reg, res_reg};
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            cnt_reg        <= '0;
            rd_vld_reg     <= 1'b0;
            m_tvalid_reg   <= 1'b0;
            temptation_reg <= 10'd384;
            cost_reg       <= 9'd64;
            inv_noise_reg  <= 16'd2560;
            long_range_reg <= '0;
            mutation_reg   <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            rd_vld_reg   <= (state_reg == ST_READ);
            m_tvalid_reg <= m_tvalid_next;
            if (cfg_valid)
            begin
                case (cfg_index)
                    CFG_TEMPTATION: temptation_reg <= cfg_data[9:0];
                    CFG_COST:       cost_reg       <= cfg_data[8:0];
                    CFG_INV_NOISE:  inv_noise_reg  <= cfg_data;
                    CFG_LONG_RANGE: long_range_reg <= cfg_data;
                    CFG_MUTATION:   mutation_reg   <= cfg_data;
                    default:        ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        m_tdata_reg <= m_tdata_next;
        rd_idx_reg  <= cnt_reg;
        if (accept_in)
        begin
            kind_reg     <= kind_t'(s_tuser);
            row_reg      <= reduce(s_tdata[6:0]);
            col_reg      <= reduce(s_tdata[13:7]);
            lv_reg       <= fold3(s_tdata[15:14]);
            dir_reg      <= s_tdata[17:16];
            lr_hit_reg   <= s_tdata[33:18] < long_range_reg;
            far_row_reg  <= reduce(s_tdata[40:34]);
            far_col_reg  <= reduce(s_tdata[47:41]);
            acc_draw_reg <= s_tdata[63:48];
            mut_hit_reg  <= s_tdata[79:64] < mutation_reg;
            mutv_reg     <= fold3(s_tdata[81:80]);
            accp_reg     <= '0;
            accf_reg     <= '0;
            imit_reg     <= 1'b0;
            mut_reg      <= 1'b0;
        end
        if (state_reg == ST_PREP)
        begin
            prow_reg <= prow_next;
            pcol_reg <= pcol_next;
            res_reg  <= lv_reg;
        end
        if (rd_vld_reg)
        begin
            if (rd_idx_reg == 4'd0)
            begin
                sx_reg <= mem_rdata;
            end
            else if (rd_idx_reg == 4'd1)
            begin
                sy_reg <= mem_rdata;
            end
            else if (rd_idx_reg <= 4'd5)
            begin
                accp_reg <= accp_reg + ACC_W'(pay(sy_reg, mem_rdata, temptation_reg, cost_reg));
            end
            else
            begin
                accf_reg <= accf_reg + ACC_W'(pay(sx_reg, mem_rdata, temptation_reg, cost_reg));
            end
        end
        if (state_reg == ST_EVAL)
        begin
            res_reg <= sx_reg;
        end
        if (state_reg == ST_FERMI && frsp.valid)
        begin
            imit_reg <= imit_next;
            mut_reg  <= mut_next;
            res_reg  <= new_val;
        end
    end

endmodule

@@ hdl/lgf_ram.sv @@
// Generic single-port synchronous RAM with a registered read.
// Depends on nothing.
module lgf_ram #(
    parameter int WIDTH = 2,
    parameter int DEPTH = 16384,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    addr,
    input  logic [WIDTH-1:0] wdata,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        else
        begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ hdl/lgf_fermi.sv @@
// Fermi adoption probability: scales the payoff difference, forms the table index
// and looks up the sigmoid. Three registered stages. Depends on lgf_pkg.
module lgf_fermi import lgf_pkg::*; #(
    parameter int SIGMOID_ENTRIES = 256
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic [15:0] inverse_noise,
    input  fermi_req_t  req,
    output fermi_rsp_t  rsp
);

    localparam int IW = (SIGMOID_ENTRIES > 1) ? $clog2(SIGMOID_ENTRIES) : 1;
    localparam int NW = IW + 1;
    localparam int ZW = 32;
    localparam int OW = 20;
    localparam int PW = OW + NW;
    localparam longint ONE_Q30 = 64'sd1 << 30;
    localparam logic signed [ZW-1:0] LIM = ZW'(1 << (OW - 1));
    localparam logic [NW-1:0] ENTRIES_N = NW'(SIGMOID_ENTRIES);
    localparam logic [IW-1:0] TOP_IDX = IW'(SIGMOID_ENTRIES - 1);

    typedef logic [PROB_W-1:0] sig_tab_t [SIGMOID_ENTRIES];

    // Shift-and-subtract quotient, evaluated only while the table is built.
    function automatic longint unsigned udiv(input longint unsigned a, input longint unsigned b);
        longint unsigned q;
        longint unsigned r;
        int i;
        q = 0;
        r = 0;
        for (i = 63; i >= 0; i--)
        begin
            r = {r[62:0], a[i]};
            if (r >= b)
            begin
                r = r - b;
                q[i] = 1'b1;
            end
        end
        return q;
    endfunction

    function automatic longint exp_neg_q30(input longint f);
        longint s;
        longint t;
        int n;
        s = ONE_Q30;
        t = ONE_Q30;
        for (n = 1; n <= 20; n++)
        begin
            t = longint'(udiv(longint'((t * f) >>> 30), longint'(n)));
            if (n % 2 == 1)
            begin
                s = s - t;
            end
            else
            begin
                s = s + t;
            end
        end
        return (s < 0) ? 64'sd0 : s;
    endfunction

    function automatic sig_tab_t build_sig();
        sig_tab_t tab;
        longint e1;
        longint m;
        longint am;
        longint k;
        longint rm;
        longint f;
        longint e;
        longint num;
        longint den;
        int i;
        int j;
        e1 = exp_neg_q30(ONE_Q30);
        for (i = 0; i < SIGMOID_ENTRIES; i++)
        begin
            m  = 2 * i + 1 - SIGMOID_ENTRIES;
            am = (m < 0) ? -m : m;
            k  = longint'(udiv(am * 8, SIGMOID_ENTRIES));
            rm = am * 8 - k * SIGMOID_ENTRIES;
            f  = longint'(udiv(rm << 30, SIGMOID_ENTRIES));
            e  = exp_neg_q30(f);
            for (j = 0; j < k; j++)
            begin
                e = (e * e1) >>> 30;
            end
            den = ONE_Q30 + e;
            num = (m >= 0) ? ONE_Q30 : e;
            tab[i] = PROB_W'(udiv((num << 16) + (den >>> 1), den));
        end
        return tab;
    endfunction

    localparam sig_tab_t SIG = build_sig();

    logic                 v1_reg, v2_reg, v3_reg;
    logic signed [ZW-1:0] z_reg;
    logic [IW-1:0]        idx_reg;
    logic [PROB_W-1:0]    prob_reg;
    logic [OW-1:0]        zoff;
    logic [PW-1:0]        prod;
    logic [IW-1:0]        idx_next;

    always_comb
    begin
        zoff = {~z_reg[OW-1], z_reg[OW-2:0]};
        prod = PW'(zoff) * PW'(ENTRIES_N);
        if (z_reg < -LIM)
        begin
            idx_next = '0;
        end
        else if (z_reg >= LIM)
        begin
            idx_next = TOP_IDX;
        end
        else
        begin
            idx_next = prod[OW +: IW];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= req.valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        z_reg    <= req.diff * $signed({1'b0, inverse_noise});
        idx_reg  <= idx_next;
        prob_reg <= SIG[idx_reg];
    end

    assign rsp.valid = v3_reg;
    assign rsp.prob  = prob_reg;

endmodule

@@ hdl/lgf_checker.sv @@
// Port-level checker for the lattice game update core, bound to the top level.
// Depends on assert_macros.svh.
`include "assert_macros.svh"

module lgf_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [7:0]  m_tdata
);

    // A result that is not taken holds still.
    `ASSERT_NEXT(a_out_hold, clk, rst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "stalled result changed")
    // Only one item is worked on at a time.
    `ASSERT_NEXT(a_one_item, clk, rst_n, s_tvalid && s_tready, !s_tready, "input taken twice in a row")
    // Every reported strategy is one of three codes.
    `ASSERT_SAME(a_cell_code, clk, rst_n, m_tvalid, m_tdata[1:0] != 2'd3, "strategy code three seen")
    // The padding bits stay clear.
    `ASSERT_SAME(a_pad_zero, clk, rst_n, m_tvalid, m_tdata[7:4] == 4'd0, "padding bits set")

endmodule

bind lattice_game_fermi_update_core lgf_checker u_lgf_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
